// ===== rtl/mpid_pkg.sv =====
// ----------------------------------------------------------------------------
// mpid_pkg : shared definitions for the modular power / inverse / divide unit
// Field widths, mode codes, step counts and the command and status words
// between the sequencer and the shared modular multiply unit.
// ----------------------------------------------------------------------------
package mpid_pkg;

   localparam int MODE_W    = 2;
   localparam int OPERAND_W = 63;
   localparam int MOD_W     = 31;
   localparam int STEP_W    = 6;
   localparam int Y_PAD     = OPERAND_W - MOD_W;

   localparam int EXP_BITS_DEFAULT = 63;

   localparam logic [MOD_W-1:0] MODULUS_RESET = 31'd1000000007;

   typedef logic [MODE_W-1:0] mode_type;

   localparam mode_type MODE_POWER   = 2'd0;
   localparam mode_type MODE_INVERSE = 2'd1;
   localparam mode_type MODE_DIVIDE  = 2'd2;
   localparam mode_type MODE_UNUSED  = 2'd3;

   // multiplier bits consumed per operation: a residue product or a full reduction
   localparam logic [STEP_W-1:0] STEPS_MUL = 6'd31;
   localparam logic [STEP_W-1:0] STEPS_RED = 6'd63;

   typedef struct packed {
      logic                  start;
      logic [MOD_W-1:0]      x;
      logic [OPERAND_W-1:0]  y;      // consumed from the top bit down
      logic [STEP_W-1:0]     steps;
   } unit_cmd_type;

   typedef struct packed {
      logic                  done;
      logic [MOD_W-1:0]      product;
   } unit_sts_type;

endpackage

// ===== rtl/mpid_if.sv =====
// ----------------------------------------------------------------------------
// mpid_if : word channels of the modular power / inverse / divide unit
// Request, response and control register channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mpid_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    mode;
   logic [62:0]                   operand_a;
   logic [62:0]                   operand_b;

   modport source (output valid, output mode, output operand_a, output operand_b,
                   input ready);
   modport sink   (input valid, input mode, input operand_a, input operand_b,
                   output ready);
endinterface

interface mpid_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [30:0]                   value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface mpid_csr_if;
   logic                          valid;
   logic                          ready;
   logic [30:0]                   data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/mpid_mulmod.sv =====
// ----------------------------------------------------------------------------
// mpid_mulmod : shared bit-serial modular multiply unit
// Computes x * y mod m, one multiplier bit a cycle, most significant first.
// With x = 1 it reduces a wide word mod m.
// ----------------------------------------------------------------------------
module mpid_mulmod (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [mpid_pkg::MOD_W-1:0]  modulus,
   input  mpid_pkg::unit_cmd_type      cmd,
   output mpid_pkg::unit_sts_type      sts
);
   import mpid_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     cnt_ff, cnt_in;
   logic [MOD_W-1:0]      acc_ff, acc_in;
   logic [MOD_W-1:0]      x_ff, x_in;
   logic [OPERAND_W-1:0]  y_ff, y_in;

   logic [MOD_W+1:0]      sum;
   logic [MOD_W+2:0]      diff1;
   logic [MOD_W+2:0]      diff2;

   // 2*acc + bit*x stays below 3m: pick the smallest non-negative of t, t-m, t-2m
   always_comb begin
      sum   = {acc_ff, 1'b0} + {2'b00, (y_ff[OPERAND_W-1] ? x_ff : '0)};
      diff1 = {1'b0, sum} - {3'b000, modulus};
      diff2 = {1'b0, sum} - {2'b00, modulus, 1'b0};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = cmd.steps;
         acc_in  = '0;
         x_in    = cmd.x;
         y_in    = cmd.y;
      end else if (busy_ff) begin
         priority if (!diff2[MOD_W+2]) begin
            acc_in = diff2[MOD_W-1:0];
         end else if (!diff1[MOD_W+2]) begin
            acc_in = diff1[MOD_W-1:0];
         end else begin
            acc_in = sum[MOD_W-1:0];
         end
         y_in   = {y_ff[OPERAND_W-2:0], 1'b0};
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
   end

   assign sts.done    = done_ff;
   assign sts.product = acc_ff;

   a_no_start_busy : assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("mulmod: start while busy");

   a_done_after_busy : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (!busy_ff && $past(busy_ff)))
      else $error("mulmod: done without a finished run");

   a_product_reduced : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (acc_ff < modulus))
      else $error("mulmod: product not reduced");

endmodule

// ===== rtl/modular_power_inverse_divide.sv =====
// ----------------------------------------------------------------------------
// modular_power_inverse_divide : modular power, Fermat inverse and divide
// Right-to-left square-and-multiply over a configured modulus, every product
// and reduction done on one shared bit-serial modular multiply unit.
// ----------------------------------------------------------------------------
//
//  channel  dir  fields                           word moved when
//  -------  ---  -------------------------------  -----------------------
//  req      in   mode, operand_a, operand_b       req.valid & req.ready
//  rsp      out  value                            rsp.valid & rsp.ready
//  csr      in   data (modulus)                   csr.valid & csr.ready
//
//  Work: a reduction of a 63-bit operand consumes 63 multiplier bits, a modular
//  product 31 multiplier bits, both on the shared unit. Power costs one
//  reduction plus up to 2*EXP_BITS-1 products, inverse one reduction plus up to
//  61 products, divide two reductions plus up to 62 products.
//  Reset returns the modulus to 1000000007 and empties the response register.
//  req.ready is high only while no word is in work; a finished word waits in
//  its own stage while the response register is held by a stalled sink.
//
module modular_power_inverse_divide #(
   parameter int EXP_BITS = mpid_pkg::EXP_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   mpid_req_if.sink    req,
   mpid_rsp_if.source  rsp,
   mpid_csr_if.sink    csr
);
   import mpid_pkg::*;

   // low EXP_BITS bits of the exponent are used in power mode
   localparam logic [OPERAND_W-1:0] EXP_MASK = {OPERAND_W{1'b1}} >> (OPERAND_W - EXP_BITS);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RED_A = 3'd1;
   localparam logic [2:0] ST_RED_B = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_SQR   = 3'd4;
   localparam logic [2:0] ST_FINAL = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic                  wait_ff, wait_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [MOD_W-1:0]      modulus_ff, modulus_in;
   mode_type              mode_ff, mode_in;
   logic [OPERAND_W-1:0]  a_ff, a_in;
   logic [OPERAND_W-1:0]  b_ff, b_in;
   logic [OPERAND_W-1:0]  exp_ff, exp_in;
   logic [MOD_W-1:0]      ra_ff, ra_in;
   logic [MOD_W-1:0]      sq_ff, sq_in;
   logic [MOD_W-1:0]      acc_ff, acc_in;
   logic [MOD_W-1:0]      res_ff, res_in;
   logic [MOD_W-1:0]      value_ff, value_in;

   logic                  out_free;
   logic [OPERAND_W-1:0]  fermat_exp;
   unit_cmd_type          cmd;
   unit_sts_type          sts;

   mpid_mulmod u_mulmod (
      .clock   (clock),
      .reset   (reset),
      .modulus (modulus_ff),
      .cmd     (cmd),
      .sts     (sts)
   );

   assign out_free   = !rsp_valid_ff || rsp.ready;
   // Fermat exponent m-2 for the inverse
   assign fermat_exp = {{Y_PAD{1'b0}}, modulus_ff - MOD_W'(2)};

   always_comb begin
      state_in     = state_ff;
      wait_in      = wait_ff;
      rsp_valid_in = rsp_valid_ff;
      modulus_in   = modulus_ff;
      mode_in      = mode_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      exp_in       = exp_ff;
      ra_in        = ra_ff;
      sq_in        = sq_ff;
      acc_in       = acc_ff;
      res_in       = res_ff;
      value_in     = value_ff;
      cmd          = '0;

      // drop the response once taken
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr.valid) begin
         modulus_in = csr.data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               mode_in = req.mode;
               a_in    = req.operand_a;
               b_in    = req.operand_b;
               wait_in = 1'b0;
               // tiny modulus or unused mode: answer zero at once
               if (modulus_ff < MOD_W'(2) || req.mode == MODE_UNUSED) begin
                  res_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_RED_A;
               end
            end
         end

         ST_RED_A: begin
            cmd.x     = MOD_W'(1);
            cmd.y     = a_ff;
            cmd.steps = STEPS_RED;
            if (!wait_ff) begin
               cmd.start = 1'b1;
               wait_in   = 1'b1;
            end else if (sts.done) begin
               wait_in = 1'b0;
               ra_in   = sts.product;
               sq_in   = sts.product;
               acc_in  = MOD_W'(1);
               priority if (mode_ff == MODE_POWER) begin
                  exp_in   = b_ff & EXP_MASK;
                  state_in = ST_MUL;
               end else if (mode_ff == MODE_INVERSE) begin
                  // zero residue has no inverse
                  if (sts.product == '0) begin
                     res_in   = '0;
                     state_in = ST_DONE;
                  end else begin
                     exp_in   = fermat_exp;
                     state_in = ST_MUL;
                  end
               end else begin
                  state_in = ST_RED_B;
               end
            end
         end

         ST_RED_B: begin
            cmd.x     = MOD_W'(1);
            cmd.y     = b_ff;
            cmd.steps = STEPS_RED;
            if (!wait_ff) begin
               cmd.start = 1'b1;
               wait_in   = 1'b1;
            end else if (sts.done) begin
               wait_in = 1'b0;
               if (sts.product == '0) begin
                  res_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  sq_in    = sts.product;
                  acc_in   = MOD_W'(1);
                  exp_in   = fermat_exp;
                  state_in = ST_MUL;
               end
            end
         end

         ST_MUL: begin
            cmd.x     = acc_ff;
            cmd.y     = {sq_ff, {Y_PAD{1'b0}}};
            cmd.steps = STEPS_MUL;
            priority if (exp_ff == '0) begin
               // exponent used up: the running product is the power
               if (mode_ff == MODE_DIVIDE) begin
                  wait_in  = 1'b0;
                  state_in = ST_FINAL;
               end else begin
                  res_in   = acc_ff;
                  state_in = ST_DONE;
               end
            end else if (!exp_ff[0]) begin
               state_in = ST_SQR;
            end else if (!wait_ff) begin
               cmd.start = 1'b1;
               wait_in   = 1'b1;
            end else if (sts.done) begin
               wait_in  = 1'b0;
               acc_in   = sts.product;
               state_in = ST_SQR;
            end
         end

         ST_SQR: begin
            cmd.x     = sq_ff;
            cmd.y     = {sq_ff, {Y_PAD{1'b0}}};
            cmd.steps = STEPS_MUL;
            // skip the square once no exponent bit is left to use it
            priority if (exp_ff[OPERAND_W-1:1] == '0) begin
               exp_in   = '0;
               state_in = ST_MUL;
            end else if (!wait_ff) begin
               cmd.start = 1'b1;
               wait_in   = 1'b1;
            end else if (sts.done) begin
               wait_in  = 1'b0;
               sq_in    = sts.product;
               exp_in   = {1'b0, exp_ff[OPERAND_W-1:1]};
               state_in = ST_MUL;
            end
         end

         ST_FINAL: begin
            cmd.x     = ra_ff;
            cmd.y     = {acc_ff, {Y_PAD{1'b0}}};
            cmd.steps = STEPS_MUL;
            if (!wait_ff) begin
               cmd.start = 1'b1;
               wait_in   = 1'b1;
            end else if (sts.done) begin
               wait_in  = 1'b0;
               res_in   = sts.product;
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            // hold the word until the response register is free
            if (out_free) begin
               value_in     = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wait_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= MODULUS_RESET;
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
         modulus_ff   <= modulus_in;
      end
      mode_ff  <= mode_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      exp_ff   <= exp_in;
      ra_ff    <= ra_in;
      sq_ff    <= sq_in;
      acc_ff   <= acc_in;
      res_ff   <= res_in;
      value_ff <= value_in;
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.value = value_ff;

   a_done_while_waiting : assert property (@(posedge clock) disable iff (reset)
      sts.done |-> wait_ff)
      else $error("sequencer: unit finished with no operation pending");

   a_result_reduced : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |-> (res_ff < modulus_ff || modulus_ff < MOD_W'(2)))
      else $error("sequencer: result not below the modulus");

   a_result_posted : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("sequencer: finished word not posted");

endmodule
